@@ hw/rtl/ppm_pkg.sv @@
// Package for the PPM stream decoder: phases, result kinds, error codes and constants.
// No dependencies.
`timescale 1ns / 1ps
package ppm_pkg;
  localparam int DimBitsDef = 16;
  localparam int MaxWordDef = 20;

  typedef enum logic [2:0] {
    PH_SKIP, PH_COMMENT_PRE, PH_WORD, PH_COMMENT_POST, PH_PIXELS, PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    CTL_IDLE, CTL_DIV, CTL_OUT
  } ctl_e;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_MAGIC    = 3'd0;
  localparam logic [2:0] ERR_END      = 3'd1;
  localparam logic [2:0] ERR_MAXVAL   = 3'd2;
  localparam logic [2:0] ERR_EMPTY    = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_SIX  = 8'h36;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_LF   = 8'h0a;

  typedef struct packed {
    logic [7:0] sample;
    logic [8:0] maxval;
  } div_req_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9) || (c == 8'd13) || (c == 8'd10);
  endfunction
endpackage

@@ hw/rtl/ppm_stream_if.sv @@
// Valid/ready channel interface carrying a generic payload.
// No dependencies.
`timescale 1ns / 1ps
interface ppm_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/ppm_divider.sv @@
// Restoring divider: floor(sample*256/(maxval+1)), saturated to 255, one bit per cycle.
// Depends on ppm_pkg.
`timescale 1ns / 1ps
module ppm_divider import ppm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  div_req_t req_i,
  output logic     done_o,
  output logic [7:0] quot_o
);
  // Dividend sample*256 has 16 bits; quotient fits in 17 but is saturated.
  logic [15:0] dvd_q, dvd_d;
  logic [9:0]  rem_q, rem_d;
  logic [9:0]  dsr_q, dsr_d;
  logic [16:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [10:0] trial;

  always_comb begin
    dvd_d = dvd_q; rem_d = rem_q; dsr_d = dsr_q; quo_d = quo_q;
    cnt_d = cnt_q; busy_d = busy_q; done_o = 1'b0;
    trial = {rem_q, dvd_q[15]} - {1'b0, dsr_q};
    if (start_i) begin
      dvd_d = {req_i.sample, 8'd0};
      rem_d = '0;
      dsr_d = {1'b0, req_i.maxval} + 10'd1;
      quo_d = '0;
      cnt_d = 5'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (!trial[10]) rem_d = trial[9:0];
        else            rem_d = {rem_q[8:0], dvd_q[15]};
        quo_d = {quo_q[15:0], ~trial[10]};
        dvd_d = {dvd_q[14:0], 1'b0};
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  assign quot_o = (quo_q > 17'd255) ? 8'd255 : quo_q[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d; rem_q <= rem_d; dsr_q <= dsr_d; quo_q <= quo_d;
  end
endmodule

@@ hw/rtl/ppm_stream_to_rgb_pixels.sv @@
// Top level of the PPM (P6) stream decoder: header parser, pixel sequencer, output register.
// Depends on ppm_pkg, ppm_stream_if and ppm_divider.
`timescale 1ns / 1ps
//
//  Channel   Direction  Word fields
//  in_ch     sink       in_byte[7:0], end_marker
//  out_ch    source     result_kind, pixel_value, last_pixel, image_width,
//                       image_height, error_code
//  cfg       write      cfg_we_i, cfg_wdata_i (out_depth_sel)
//
// Header bytes need no divider and are parsed as they are accepted. A sample
// byte loads the shared restoring divider, which works through a 16-bit dividend
// bit by bit; no new word is taken until the quotient has been handed over.
// A pending result is held in an output register; while it waits, no new word
// is taken unless the receiver takes the result in that same cycle.
// Reset (asynchronous, active low) returns the parser to skipping whitespace
// before the magic word and clears the format register to RGB888.
module ppm_stream_to_rgb_pixels import ppm_pkg::*; #(
  parameter int DIM_BITS = DimBitsDef,
  parameter int MAX_WORD = MaxWordDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppm_stream_if.sink   in_ch,
  ppm_stream_if.source out_ch,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  localparam int AccBits = DIM_BITS + 1;
  localparam logic [AccBits-1:0] Sat = AccBits'(1) << DIM_BITS;

  // Input payload {in_byte, end_marker}; output payload fields are driven below.
  logic [7:0] in_byte;
  logic       end_marker;
  assign in_byte    = in_ch.data.in_byte;
  assign end_marker = in_ch.data.end_marker;

  logic depth_q;
  phase_e ph_q, ph_d;
  ctl_e   ctl_q, ctl_d;
  logic [1:0] widx_q, widx_d;
  logic [4:0] wlen_q, wlen_d;
  logic [AccBits-1:0] acc_q, acc_d;
  logic stop_q, stop_d, magic_q, magic_d;
  logic [AccBits-1:0] w_q, w_d, h_q, h_d;
  logic [8:0] maxv_q, maxv_d;
  logic [1:0] ch_q, ch_d;
  logic [7:0] red_q, red_d, grn_q, grn_d;
  logic [DIM_BITS-1:0] col_q, col_d, row_q, row_d;

  // Output register.
  logic       ov_q, ov_d;
  logic [1:0] okind_q, okind_d;
  logic [23:0] opix_q, opix_d;
  logic       olast_q, olast_d;
  logic [15:0] ow_q, ow_d, oh_q, oh_d;
  logic [2:0] oerr_q, oerr_d;

  logic     div_start, div_done;
  div_req_t div_req;
  logic [7:0] quot;

  ppm_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .req_i(div_req),
    .done_o(div_done), .quot_o(quot)
  );

  logic accept;
  logic slot_free;
  assign slot_free = !ov_q || out_ch.ready;
  // Only the idle sequencer takes words, and only with a free output slot.
  assign in_ch.ready = (ctl_q == CTL_IDLE) && slot_free;
  assign accept = in_ch.valid && in_ch.ready;

  assign div_req.sample = in_byte;
  assign div_req.maxval = maxv_q;

  // Next state for the sequencer.
  always_comb begin
    ctl_d = ctl_q;
    unique case (ctl_q)
      CTL_IDLE: if (accept && !end_marker && ph_q == PH_PIXELS) ctl_d = CTL_DIV;
      CTL_DIV:  if (div_done) ctl_d = CTL_IDLE;
      default:  ctl_d = CTL_IDLE;
    endcase
  end
  assign div_start = (ctl_q == CTL_IDLE) && accept && !end_marker && ph_q == PH_PIXELS;

  logic [AccBits+3:0] acc_x10;
  logic [AccBits+3:0] acc_new;
  logic [7:0] pix_b;
  logic       last_hit;

  always_comb begin
    ph_d = ph_q; widx_d = widx_q; wlen_d = wlen_q; acc_d = acc_q;
    stop_d = stop_q; magic_d = magic_q; w_d = w_q; h_d = h_q; maxv_d = maxv_q;
    ch_d = ch_q; red_d = red_q; grn_d = grn_q; col_d = col_q; row_d = row_q;
    ov_d = ov_q && !out_ch.ready;
    okind_d = okind_q; opix_d = opix_q; olast_d = olast_q;
    ow_d = ow_q; oh_d = oh_q; oerr_d = oerr_q;
    acc_x10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1);
    acc_new = acc_x10 + (AccBits+4)'(in_byte - 8'h30);
    pix_b = quot;
    last_hit = ((col_q + 1'b1) == w_q[DIM_BITS-1:0]) && ((row_q + 1'b1) == h_q[DIM_BITS-1:0]);

    if (accept && end_marker) begin
      if (ph_q != PH_HALT) begin
        ov_d = 1'b1; okind_d = KIND_ERROR; opix_d = '0; olast_d = 1'b0;
        ow_d = '0; oh_d = '0;
        oerr_d = (ph_q == PH_PIXELS || widx_q != 2'd0) ? ERR_END : ERR_MAGIC;
      end
      ph_d = PH_SKIP; widx_d = '0; wlen_d = '0; acc_d = '0; stop_d = 1'b0;
      magic_d = 1'b1; w_d = '0; h_d = '0; maxv_d = '0; ch_d = '0;
      red_d = '0; grn_d = '0; col_d = '0; row_d = '0;
    end else if (accept && ph_q != PH_PIXELS) begin
      logic do_store, do_done;
      do_store = 1'b0; do_done = 1'b0;
      unique case (ph_q)
        PH_SKIP: begin
          if (in_byte == CHAR_HASH) ph_d = PH_COMMENT_PRE;
          else if (!is_space(in_byte)) begin ph_d = PH_WORD; do_store = 1'b1; end
        end
        PH_COMMENT_PRE: if (in_byte == CHAR_LF) ph_d = PH_SKIP;
        PH_WORD: begin
          if (wlen_q >= 5'(MAX_WORD) || is_space(in_byte)) do_done = 1'b1;
          else if (in_byte == CHAR_HASH) ph_d = PH_COMMENT_POST;
          else do_store = 1'b1;
        end
        PH_COMMENT_POST: if (in_byte == CHAR_LF) do_done = 1'b1;
        default: ;
      endcase
      if (do_store) begin
        if (wlen_q == 5'd0 && in_byte != CHAR_P) magic_d = 1'b0;
        if (wlen_q == 5'd1 && in_byte != CHAR_SIX) magic_d = 1'b0;
        if (!stop_q && in_byte >= 8'h30 && in_byte <= 8'h39)
          acc_d = (acc_new > {4'd0, Sat}) ? Sat : acc_new[AccBits-1:0];
        else stop_d = 1'b1;
        wlen_d = wlen_q + 5'd1;
      end
      if (do_done) begin
        wlen_d = '0; acc_d = '0; stop_d = 1'b0; magic_d = 1'b1; ph_d = PH_SKIP;
        widx_d = widx_q + 2'd1;
        ov_d = 1'b0;
        okind_d = KIND_ERROR; opix_d = '0; olast_d = 1'b0; ow_d = '0; oh_d = '0;
        unique case (widx_q)
          2'd0: if (!(wlen_q == 5'd2 && magic_q)) begin
            ov_d = 1'b1; oerr_d = ERR_MAGIC; ph_d = PH_HALT;
          end else ov_d = ov_q && !out_ch.ready;
          2'd1: begin w_d = acc_q; ov_d = ov_q && !out_ch.ready; end
          2'd2: begin h_d = acc_q; ov_d = ov_q && !out_ch.ready; end
          default: begin
            maxv_d = (acc_q > AccBits'(256)) ? 9'd256 : acc_q[8:0];
            ov_d = 1'b1;
            if (acc_q > AccBits'(255)) begin oerr_d = ERR_MAXVAL; ph_d = PH_HALT; end
            else if (w_q >= Sat || h_q >= Sat) begin
              oerr_d = ERR_OVERFLOW; ph_d = PH_HALT;
            end else if (w_q == '0 || h_q == '0) begin
              oerr_d = ERR_EMPTY; ph_d = PH_HALT;
            end else begin
              okind_d = KIND_HEADER; oerr_d = '0;
              ow_d = 16'(w_q[DIM_BITS-1:0]); oh_d = 16'(h_q[DIM_BITS-1:0]);
              ph_d = PH_PIXELS; ch_d = '0; col_d = '0; row_d = '0;
            end
          end
        endcase
      end
    end else if (ctl_q == CTL_DIV && div_done) begin
      unique case (ch_q)
        2'd0: begin red_d = pix_b; ch_d = 2'd1; end
        2'd1: begin grn_d = pix_b; ch_d = 2'd2; end
        default: begin
          ch_d = '0;
          ov_d = 1'b1; okind_d = KIND_PIXEL; ow_d = '0; oh_d = '0; oerr_d = '0;
          opix_d = depth_q ? {8'd0, red_q[7:3], grn_q[7:2], pix_b[7:3]}
                           : {red_q, grn_q, pix_b};
          olast_d = last_hit;
          if (last_hit) ph_d = PH_HALT;
          else if ((col_q + 1'b1) >= w_q[DIM_BITS-1:0]) begin
            col_d = '0; row_d = row_q + 1'b1;
          end else col_d = col_q + 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= 1'b0; ph_q <= PH_SKIP; ctl_q <= CTL_IDLE; widx_q <= '0;
      wlen_q <= '0; acc_q <= '0; stop_q <= 1'b0; magic_q <= 1'b1;
      w_q <= '0; h_q <= '0; maxv_q <= '0; ch_q <= '0; red_q <= '0; grn_q <= '0;
      col_q <= '0; row_q <= '0; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) depth_q <= cfg_wdata_i;
      ph_q <= ph_d; ctl_q <= ctl_d; widx_q <= widx_d; wlen_q <= wlen_d;
      acc_q <= acc_d; stop_q <= stop_d; magic_q <= magic_d; w_q <= w_d; h_q <= h_d;
      maxv_q <= maxv_d; ch_q <= ch_d; red_q <= red_d; grn_q <= grn_d;
      col_q <= col_d; row_q <= row_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d; opix_q <= opix_d; olast_q <= olast_d;
    ow_q <= ow_d; oh_q <= oh_d; oerr_q <= oerr_d;
  end

  assign out_ch.valid             = ov_q;
  assign out_ch.data.result_kind  = okind_q;
  assign out_ch.data.pixel_value  = opix_q;
  assign out_ch.data.last_pixel   = olast_q;
  assign out_ch.data.image_width  = ow_q;
  assign out_ch.data.image_height = oh_q;
  assign out_ch.data.error_code   = oerr_q;
endmodule

@@ dv/tb.sv @@
// Self-checking testbench for ppm_stream_to_rgb_pixels: drives whole PPM files
// byte by byte, predicts each result and compares it field by field.
// Depends on ppm_pkg, ppm_stream_if and the decoder RTL.
`timescale 1ns / 1ps
module tb;
  import ppm_pkg::*;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_marker;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [23:0] pixel_value;
    logic        last_pixel;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  error_code;
  } out_word_t;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  ppm_stream_if #(.payload_t(in_word_t)) in_if ();
  ppm_stream_if #(.payload_t(out_word_t)) out_if ();

  ppm_stream_to_rgb_pixels i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // Words waiting to be sent, results still owed by the decoder.
  in_word_t  file_bytes_q[$];
  out_word_t owed_results_q[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        src_idle_pct = 0;
  int        sink_stall_pct = 0;
  logic      took = 1'b0;

  // Shadow copy of the decoder state.
  phase_e      ph;
  logic [1:0]  widx;
  logic [4:0]  wlen;
  logic [16:0] acc;
  logic        stopped, magic_ok;
  logic [16:0] img_w, img_h;
  logic [8:0]  maxv;
  logic [1:0]  chan;
  logic [7:0]  red_s, green_s;
  logic [15:0] col, row;
  logic        rgb565;

  function automatic logic is_space_c(logic [7:0] c);
    return c == 8'd32 || c == 8'd9 || c == 8'd13 || c == 8'd10;
  endfunction

  task automatic rearm();
    ph = PH_SKIP; widx = '0; wlen = '0; acc = '0; stopped = 1'b0; magic_ok = 1'b1;
    img_w = '0; img_h = '0; maxv = '0; chan = '0; red_s = '0; green_s = '0;
    col = '0; row = '0;
  endtask

  task automatic owe(logic [1:0] kind, logic [23:0] pix, logic last, logic [15:0] w,
                     logic [15:0] h, logic [2:0] err);
    out_word_t r;
    r.result_kind = kind; r.pixel_value = pix; r.last_pixel = last;
    r.image_width = w; r.image_height = h; r.error_code = err;
    owed_results_q.push_back(r);
  endtask

  task automatic halt_with(logic [2:0] err);
    ph = PH_HALT;
    owe(KIND_ERROR, '0, 1'b0, '0, '0, err);
  endtask

  task automatic take_char(logic [7:0] c);
    int v;
    if (wlen == 0 && c != CHAR_P) magic_ok = 1'b0;
    if (wlen == 1 && c != CHAR_SIX) magic_ok = 1'b0;
    if (!stopped && c >= "0" && c <= "9") begin
      v = int'(acc) * 10 + int'(c) - int'("0");
      acc = (v > 65536) ? 17'd65536 : v[16:0];
    end else begin
      stopped = 1'b1;
    end
    wlen = wlen + 5'd1;
  endtask

  // Closes the current header word and checks the header once maxval is in.
  task automatic close_word();
    logic [1:0]  idx;
    logic [16:0] val;
    logic        good;
    idx = widx; val = acc; good = (wlen == 2) && magic_ok;
    wlen = '0; acc = '0; stopped = 1'b0; magic_ok = 1'b1; ph = PH_SKIP;
    widx = widx + 2'd1;
    case (idx)
      2'd0: if (!good) halt_with(ERR_MAGIC);
      2'd1: img_w = val;
      2'd2: img_h = val;
      default: begin
        maxv = (val > 256) ? 9'd256 : val[8:0];
        if (maxv > 255) halt_with(ERR_MAXVAL);
        else if (img_w >= 65536 || img_h >= 65536) halt_with(ERR_OVERFLOW);
        else if (img_w == 0 || img_h == 0) halt_with(ERR_EMPTY);
        else begin
          ph = PH_PIXELS; chan = '0; col = '0; row = '0;
          owe(KIND_HEADER, '0, 1'b0, img_w[15:0], img_h[15:0], '0);
        end
      end
    endcase
  endtask

  task automatic decode_word(in_word_t w);
    logic [7:0]  c;
    int          q;
    logic [7:0]  s;
    logic [23:0] pix;
    logic        last;
    c = w.in_byte;
    if (w.end_marker) begin
      if (ph == PH_PIXELS) halt_with(ERR_END);
      else if (ph != PH_HALT) halt_with(widx == 0 ? ERR_MAGIC : ERR_END);
      rearm();
      return;
    end
    case (ph)
      PH_SKIP:
        if (c == CHAR_HASH) ph = PH_COMMENT_PRE;
        else if (!is_space_c(c)) begin
          ph = PH_WORD;
          take_char(c);
        end
      PH_COMMENT_PRE: if (c == CHAR_LF) ph = PH_SKIP;
      PH_WORD:
        if (wlen >= 20 || is_space_c(c)) close_word();
        else if (c == CHAR_HASH) ph = PH_COMMENT_POST;
        else take_char(c);
      PH_COMMENT_POST: if (c == CHAR_LF) close_word();
      PH_PIXELS: begin
        q = (int'(c) * 256) / (int'(maxv) + 1);
        s = (q > 255) ? 8'd255 : q[7:0];
        if (chan == 0) begin
          red_s = s; chan = 2'd1;
        end else if (chan == 1) begin
          green_s = s; chan = 2'd2;
        end else begin
          chan = '0;
          if (rgb565) pix = {8'd0, red_s[7:3], green_s[7:2], s[7:3]};
          else pix = {red_s, green_s, s};
          last = (col + 1 == img_w) && (row + 1 == img_h);
          if (last) ph = PH_HALT;
          else begin
            col = col + 16'd1;
            if (col >= img_w) begin
              col = '0; row = row + 16'd1;
            end
          end
          owe(KIND_PIXEL, pix, last, '0, '0, '0);
        end
      end
      default: ;
    endcase
  endtask

  // Stimulus helpers: they only queue words.
  task automatic put(logic [7:0] b);
    in_word_t w;
    w.in_byte = b; w.end_marker = 1'b0;
    file_bytes_q.push_back(w);
  endtask

  task automatic put_end();
    in_word_t w;
    w.in_byte = 8'($urandom_range(255)); w.end_marker = 1'b1;
    file_bytes_q.push_back(w);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // Random whitespace, sometimes with a comment line.
  task automatic put_gap();
    logic [7:0] ws[4] = '{8'd32, 8'd9, 8'd13, 8'd10};
    int n;
    n = $urandom_range(1, 2);
    for (int i = 0; i < n; i++) put(ws[$urandom_range(3)]);
    if ($urandom_range(5) == 0) begin
      put(CHAR_HASH);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) put(8'($urandom_range(11, 255)));
      put(CHAR_LF);
    end
  endtask

  // One random file; most are well formed so the pixel path gets exercised.
  task automatic put_file();
    int kind, w, h, mv, n;
    kind = $urandom_range(0, 11);
    w = ($urandom_range(7) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 3);
    h = $urandom_range(1, 3);
    mv = ($urandom_range(3) == 0) ? 255 : $urandom_range(0, 255);
    if (kind == 9) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) put(8'($urandom_range(255)));
      put_end();
      return;
    end
    if (kind == 10) put_text("P3");
    else if (kind == 11) put_text("P66");
    else put_text("P6");
    put_gap();
    put_text($sformatf("%0d", w));
    put_gap();
    put_text($sformatf("%0d", h));
    put_gap();
    if (kind == 8 && $urandom_range(1) == 0) begin
      put_end();
      return;
    end
    put_text($sformatf("%0d", mv));
    put($urandom_range(1) ? 8'd10 : 8'd32);
    n = 3 * w * h;
    if (kind == 8) n = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) put(8'($urandom_range(255)));
    if (kind == 7) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) put(8'($urandom_range(255)));
    end
    put_end();
  endtask

  task automatic write_depth(logic v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    rgb565 = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Predict on acceptance, check each result as it leaves.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("ppm_stream_to_rgb_pixels verification failed");
      $finish;
    end
    took = in_if.valid && in_if.ready;
    if (took) begin
      decode_word(file_bytes_q.pop_front());
    end
    if (out_if.valid && out_if.ready) begin
      if (owed_results_q.size() == 0) begin
        $error("result with nothing expected: kind %0d", out_if.data.result_kind);
        mismatches++;
      end else begin
        out_word_t e;
        e = owed_results_q.pop_front();
        if (e.result_kind !== out_if.data.result_kind) begin
          $error("result_kind exp %0h got %0h", e.result_kind, out_if.data.result_kind);
          mismatches++;
        end
        if (e.pixel_value !== out_if.data.pixel_value) begin
          $error("pixel_value exp %0h got %0h", e.pixel_value, out_if.data.pixel_value);
          mismatches++;
        end
        if (e.last_pixel !== out_if.data.last_pixel) begin
          $error("last_pixel exp %0h got %0h", e.last_pixel, out_if.data.last_pixel);
          mismatches++;
        end
        if (e.image_width !== out_if.data.image_width) begin
          $error("image_width exp %0h got %0h", e.image_width, out_if.data.image_width);
          mismatches++;
        end
        if (e.image_height !== out_if.data.image_height) begin
          $error("image_height exp %0h got %0h", e.image_height,
                 out_if.data.image_height);
          mismatches++;
        end
        if (e.error_code !== out_if.data.error_code) begin
          $error("error_code exp %0h got %0h", e.error_code, out_if.data.error_code);
          mismatches++;
        end
      end
    end
  end

  // Driver: a word stays on the bus until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || took) begin
        if (file_bytes_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data <= file_bytes_q[0];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    int idle_src[4] = '{0, 75, 0, 14};
    int idle_sink[4] = '{0, 0, 75, 14};
    int start;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    rgb565 = 1'b0;
    rearm();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = idle_src[p];
      sink_stall_pct = idle_sink[p];
      write_depth(p[0] ? 1'b0 : 1'b1);
      if (p == 0) begin
        put_end();                                     // empty file
        put_text("P5 "); put_end();                    // wrong magic
        put_text("P6 0 1 255 "); put_end();            // empty image
        put_text("P6 65536 1 9\n"); put_end();         // width too large
        put_text("P6 1 1 256 "); put_end();            // maxval too large
        put_text("P6 3"); put_end();                   // truncated header
        put_text("P6 1#c\n1 0 "); put(8'hff); put(8'h00); put(8'h80);
        put(8'h55); put_end();                         // comment in word, maxval 0
        put_text("P6 99999999999999999999999 1 255\n"); put_end();
      end
      start = file_bytes_q.size();
      while (file_bytes_q.size() - start < 80) put_file();
      while (file_bytes_q.size() > 0 || owed_results_q.size() > 0) @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);
    end
    if (mismatches == 0 && owed_results_q.size() == 0) begin
      $display("ppm_stream_to_rgb_pixels verification clean");
    end else begin
      $display("ppm_stream_to_rgb_pixels verification failed");
    end
    $finish;
  end
endmodule
